@@ rtl/vac_pkg.sv @@
// Shared types, codes and helpers of the virtual machine execute unit.
package vac_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned OUT_W          = 32;

  typedef enum logic [4:0] {
    FN_MOV  = 5'd0,
    FN_ADD  = 5'd1,
    FN_SUB  = 5'd2,
    FN_MUL  = 5'd3,
    FN_DIV  = 5'd4,
    FN_CMP  = 5'd5,
    FN_SHL  = 5'd6,
    FN_SHR  = 5'd7,
    FN_SAR  = 5'd8,
    FN_AND  = 5'd9,
    FN_OR   = 5'd10,
    FN_XOR  = 5'd11,
    FN_SWAP = 5'd12,
    FN_LDL  = 5'd13,
    FN_LDH  = 5'd14,
    FN_JMP  = 5'd15,
    FN_JZ   = 5'd16,
    FN_JP   = 5'd17,
    FN_JN   = 5'd18,
    FN_JNZ  = 5'd19,
    FN_JNP  = 5'd20,
    FN_JNN  = 5'd21,
    FN_NOT  = 5'd22,
    FN_STOP = 5'd23
  } vac_func_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_DIV_ZERO = 2'd1,
    ERR_INVALID  = 2'd2
  } vac_err_e;

  typedef enum logic [1:0] {
    CC_POS  = 2'd0,
    CC_ZERO = 2'd1,
    CC_NEG  = 2'd2
  } vac_cc_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_ABSA,
    ST_ABSB,
    ST_DIV,
    ST_NEGQ,
    ST_NEGR,
    ST_DONE
  } vac_state_e;

  // Finished result of one item, handed from the sequencer to the output stage.
  typedef struct packed {
    logic [OUT_W-1:0] ra;
    logic [OUT_W-1:0] rb;
    logic [OUT_W-1:0] rem;
    logic             wa;
    logic             wb;
    logic             wr;
    logic             setcc;
    vac_cc_e          cc;
    logic             br;
    logic             halt;
    vac_err_e         err;
  } vac_result_t;

  // Condition code of a sign-extended result.
  function automatic vac_cc_e vac_cc_of(logic [OUT_W-1:0] v);
    vac_cc_e c;
    if (v == '0) begin
      c = CC_ZERO;
    end else if (v[OUT_W-1]) begin
      c = CC_NEG;
    end else begin
      c = CC_POS;
    end
    return c;
  endfunction

endpackage

@@ rtl/vac_addsub.sv @@
// Shared adder and subtractor used by every arithmetic step of the execute unit.
module vac_addsub #(
  parameter int unsigned WIDTH = vac_pkg::DATA_WIDTH_DEF + 1
) (
  input  logic [WIDTH-1:0] x_i,
  input  logic [WIDTH-1:0] y_i,
  input  logic             sub_i,
  output logic [WIDTH-1:0] sum_o
);

  logic [WIDTH-1:0] y_eff;

  assign y_eff = sub_i ? ~y_i : y_i;
  assign sum_o = x_i + y_eff + {{(WIDTH-1){1'b0}}, sub_i};

endmodule

@@ rtl/vac_core.sv @@
// Sequencer and operand registers of the execute unit around the shared adder.
module vac_core #(
  parameter int unsigned DATA_WIDTH = vac_pkg::DATA_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  vac_pkg::vac_func_e     func_i,
  input  logic [DATA_WIDTH-1:0]  a_i,
  input  logic [DATA_WIDTH-1:0]  b_i,
  input  vac_pkg::vac_cc_e       cc_i,
  input  logic                   slot_free_i,
  output logic                   idle_o,
  output logic                   done_o,
  output vac_pkg::vac_result_t   res_o
);

  localparam int unsigned DW    = DATA_WIDTH;
  localparam int unsigned AW    = DW + 1;
  localparam int unsigned CNT_W = $clog2(DW);
  localparam int unsigned SH_W  = $clog2(DW);
  localparam int unsigned HALF  = DW / 2;
  localparam logic [DW-1:0] LOW_MASK = {{(DW-HALF){1'b0}}, {HALF{1'b1}}};

  vac_pkg::vac_state_e  state_q, state_d;
  vac_pkg::vac_func_e   func_q, func_d;
  logic [DW-1:0]        a_q, a_d, b_q, b_d;
  logic [AW-1:0]        acc_q, acc_d;
  logic [DW-1:0]        q_q, q_d, m_q, m_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  vac_pkg::vac_result_t res_q, res_d;

  logic [AW-1:0] add_x, add_y, sum;
  logic          add_sub;
  logic          shift_ok;
  logic [SH_W-1:0] sh;
  logic          last_step;

  function automatic logic [vac_pkg::OUT_W-1:0] sext(logic [DW-1:0] v);
    return vac_pkg::OUT_W'($signed(v));
  endfunction

  vac_addsub #(
    .WIDTH(AW)
  ) u_addsub (
    .x_i  (add_x),
    .y_i  (add_y),
    .sub_i(add_sub),
    .sum_o(sum)
  );

  assign shift_ok  = !b_q[DW-1] && (b_q < DW'(DW));
  assign sh        = b_q[SH_W-1:0];
  assign last_step = (cnt_q == CNT_W'(DW - 1));

  // Operand selection for the shared adder.
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      vac_pkg::ST_EXEC: begin
        add_x   = {a_q[DW-1], a_q};
        add_y   = {b_q[DW-1], b_q};
        add_sub = (func_q == vac_pkg::FN_SUB) || (func_q == vac_pkg::FN_CMP);
      end
      vac_pkg::ST_MUL: begin
        add_x = {1'b0, acc_q[DW-1:0]};
        add_y = {1'b0, m_q};
      end
      vac_pkg::ST_ABSA, vac_pkg::ST_NEGQ: begin
        add_y   = {1'b0, q_q};
        add_sub = 1'b1;
      end
      vac_pkg::ST_ABSB: begin
        add_y   = {1'b0, m_q};
        add_sub = 1'b1;
      end
      vac_pkg::ST_DIV: begin
        add_x   = {acc_q[DW-1:0], q_q[DW-1]};
        add_y   = {1'b0, m_q};
        add_sub = 1'b1;
      end
      vac_pkg::ST_NEGR: begin
        add_y   = {1'b0, acc_q[DW-1:0]};
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    logic [DW-1:0] v;
    logic [DW-1:0] remv;
    v       = '0;
    remv    = '0;
    state_d = state_q;
    func_d  = func_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    q_d     = q_q;
    m_d     = m_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    unique case (state_q)
      vac_pkg::ST_IDLE: begin
        if (start_i) begin
          func_d  = func_i;
          a_d     = a_i;
          b_d     = b_i;
          state_d = vac_pkg::ST_EXEC;
        end
      end
      vac_pkg::ST_EXEC: begin
        res_d   = '0;
        state_d = vac_pkg::ST_DONE;
        unique case (func_q)
          vac_pkg::FN_MOV: begin
            res_d.ra = sext(b_q);
            res_d.wa = 1'b1;
          end
          vac_pkg::FN_ADD, vac_pkg::FN_SUB, vac_pkg::FN_CMP: begin
            res_d.wa    = (func_q != vac_pkg::FN_CMP);
            res_d.ra    = res_d.wa ? sext(sum[DW-1:0]) : '0;
            res_d.setcc = 1'b1;
            res_d.cc    = vac_pkg::vac_cc_of(sext(sum[DW-1:0]));
          end
          vac_pkg::FN_MUL: begin
            acc_d   = '0;
            m_d     = a_q;
            q_d     = b_q;
            cnt_d   = '0;
            state_d = vac_pkg::ST_MUL;
          end
          vac_pkg::FN_DIV: begin
            if (b_q == '0) begin
              res_d.err = vac_pkg::ERR_DIV_ZERO;
            end else begin
              q_d     = a_q;
              m_d     = b_q;
              state_d = vac_pkg::ST_ABSA;
            end
          end
          vac_pkg::FN_SHL, vac_pkg::FN_SHR, vac_pkg::FN_SAR: begin
            if (!shift_ok) begin
              res_d.err = vac_pkg::ERR_INVALID;
            end else begin
              if (func_q == vac_pkg::FN_SHL) begin
                v = a_q << sh;
              end else if (func_q == vac_pkg::FN_SHR) begin
                v           = a_q >> sh;
                res_d.setcc = 1'b1;
              end else begin
                v           = $unsigned($signed(a_q) >>> sh);
                res_d.setcc = 1'b1;
              end
              res_d.ra = sext(v);
              res_d.wa = 1'b1;
              res_d.cc = vac_pkg::vac_cc_of(sext(v));
            end
          end
          vac_pkg::FN_AND, vac_pkg::FN_OR, vac_pkg::FN_XOR, vac_pkg::FN_NOT: begin
            if (func_q == vac_pkg::FN_AND) begin
              v = a_q & b_q;
            end else if (func_q == vac_pkg::FN_OR) begin
              v = a_q | b_q;
            end else if (func_q == vac_pkg::FN_XOR) begin
              v = a_q ^ b_q;
            end else begin
              v = ~a_q;
            end
            res_d.ra    = sext(v);
            res_d.wa    = 1'b1;
            res_d.setcc = 1'b1;
            res_d.cc    = vac_pkg::vac_cc_of(sext(v));
          end
          vac_pkg::FN_SWAP: begin
            res_d.ra = sext(b_q);
            res_d.rb = sext(a_q);
            res_d.wa = 1'b1;
            res_d.wb = 1'b1;
          end
          vac_pkg::FN_LDL: begin
            res_d.ra = sext((a_q & ~LOW_MASK) | (b_q & LOW_MASK));
            res_d.wa = 1'b1;
          end
          vac_pkg::FN_LDH: begin
            res_d.ra = sext((a_q & LOW_MASK) | ((b_q & LOW_MASK) << HALF));
            res_d.wa = 1'b1;
          end
          vac_pkg::FN_JMP:  res_d.br = 1'b1;
          vac_pkg::FN_JZ:   res_d.br = cc_i[0];
          vac_pkg::FN_JP:   res_d.br = (cc_i == vac_pkg::CC_POS);
          vac_pkg::FN_JN:   res_d.br = (cc_i == vac_pkg::CC_NEG);
          vac_pkg::FN_JNZ:  res_d.br = (cc_i != vac_pkg::CC_ZERO);
          vac_pkg::FN_JNP:  res_d.br = (cc_i != vac_pkg::CC_POS);
          vac_pkg::FN_JNN:  res_d.br = (cc_i != vac_pkg::CC_NEG);
          vac_pkg::FN_STOP: res_d.halt = 1'b1;
          default:          res_d.err = vac_pkg::ERR_INVALID;
        endcase
      end
      vac_pkg::ST_MUL: begin
        if (q_q[0]) begin
          acc_d = {1'b0, sum[DW-1:0]};
        end
        m_d   = m_q << 1;
        q_d   = q_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (last_step) begin
          res_d.ra    = sext(acc_d[DW-1:0]);
          res_d.wa    = 1'b1;
          res_d.setcc = 1'b1;
          res_d.cc    = vac_pkg::vac_cc_of(sext(acc_d[DW-1:0]));
          state_d     = vac_pkg::ST_DONE;
        end
      end
      vac_pkg::ST_ABSA: begin
        if (a_q[DW-1]) begin
          q_d = sum[DW-1:0];
        end
        state_d = vac_pkg::ST_ABSB;
      end
      vac_pkg::ST_ABSB: begin
        if (b_q[DW-1]) begin
          m_d = sum[DW-1:0];
        end
        acc_d   = '0;
        cnt_d   = '0;
        state_d = vac_pkg::ST_DIV;
      end
      vac_pkg::ST_DIV: begin
        if (!sum[DW]) begin
          acc_d = sum;
          q_d   = {q_q[DW-2:0], 1'b1};
        end else begin
          acc_d = {acc_q[DW-1:0], q_q[DW-1]};
          q_d   = {q_q[DW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (last_step) begin
          state_d = vac_pkg::ST_NEGQ;
        end
      end
      vac_pkg::ST_NEGQ: begin
        if (a_q[DW-1] ^ b_q[DW-1]) begin
          q_d = sum[DW-1:0];
        end
        state_d = vac_pkg::ST_NEGR;
      end
      vac_pkg::ST_NEGR: begin
        remv        = a_q[DW-1] ? sum[DW-1:0] : acc_q[DW-1:0];
        res_d.ra    = sext(q_q);
        res_d.wa    = 1'b1;
        res_d.rem   = sext(remv);
        res_d.wr    = 1'b1;
        res_d.setcc = 1'b1;
        res_d.cc    = vac_pkg::vac_cc_of(sext(q_q));
        state_d     = vac_pkg::ST_DONE;
      end
      vac_pkg::ST_DONE: begin
        if (slot_free_i) begin
          state_d = vac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vac_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vac_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    q_q    <= q_d;
    m_q    <= m_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  assign idle_o = (state_q == vac_pkg::ST_IDLE);
  assign done_o = (state_q == vac_pkg::ST_DONE);
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vac_pkg::ST_DIV) && last_step |=> (state_q == vac_pkg::ST_NEGQ))
    else $error("divider left its loop at the wrong step");
  a_mul_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vac_pkg::ST_MUL) && !last_step |=> (state_q == vac_pkg::ST_MUL))
    else $error("multiplier left its loop early");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && (state_q == vac_pkg::ST_IDLE) |=> (state_q == vac_pkg::ST_EXEC))
    else $error("accepted item did not enter execution");
`endif

endmodule

@@ rtl/vm_alu_with_condition_codes_top.sv @@
// Top level of the virtual machine execute unit: handshakes, result register, condition code.
// Single-step operations pass through the execute step alone; mul adds a loop that takes
// one multiplier bit per cycle, and div adds sign fix-ups around a loop that takes one
// quotient bit per cycle, all through the one shared adder. The sequencer holds one item
// at a time and takes a new one only after its result has gone to the result register.
// Reset (rst_ni low, asynchronous) empties the result register, returns the sequencer to
// idle and clears the kept condition code to positive (0).
module vm_alu_with_condition_codes_top #(
  parameter int unsigned DATA_WIDTH = vac_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input channel: one operation with its two operand values.
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [4:0]                  func_i,
  input  logic signed [31:0]          a_value_i,
  input  logic signed [31:0]          b_value_i,
  // Output channel: one result item per input item.
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [31:0]          result_a_o,
  output logic                        write_a_o,
  output logic signed [31:0]          result_b_o,
  output logic                        write_b_o,
  output logic signed [31:0]          remainder_o,
  output logic                        write_remainder_o,
  output logic [1:0]                  cond_code_o,
  output logic                        branch_taken_o,
  output logic                        halt_o,
  output logic [1:0]                  error_code_o
);

  logic                 core_idle;
  logic                 core_done;
  logic                 slot_free;
  logic                 load;
  vac_pkg::vac_result_t core_res;

  // Condition code kept between items, and the registered result item.
  vac_pkg::vac_cc_e     cc_q, cc_d;
  logic                 out_valid_q, out_valid_d;
  vac_pkg::vac_result_t out_res_q;
  vac_pkg::vac_cc_e     out_cc_q;

  // The sequencer takes a new item only when idle. Operands are cut to the
  // working width here; results come back already sign-extended to 32 bits.
  assign in_ready_o = core_idle;

  // The result register may be refilled in the same cycle that its item is taken.
  assign slot_free = !out_valid_q || out_ready_i;
  assign load      = core_done && slot_free;

  vac_core #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_valid_i),
    .func_i     (vac_pkg::vac_func_e'(func_i)),
    .a_i        (a_value_i[DATA_WIDTH-1:0]),
    .b_i        (b_value_i[DATA_WIDTH-1:0]),
    .cc_i       (cc_q),
    .slot_free_i(slot_free),
    .idle_o     (core_idle),
    .done_o     (core_done),
    .res_o      (core_res)
  );

  // The condition code moves on when the item that sets it is delivered to the
  // result register; jumps of the next item then see the updated value.
  always_comb begin
    cc_d        = cc_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      if (core_res.setcc) begin
        cc_d = core_res.cc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q        <= vac_pkg::CC_POS;
      out_valid_q <= 1'b0;
    end else begin
      cc_q        <= cc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_res_q <= core_res;
      out_cc_q  <= cc_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_a_o        = out_res_q.ra;
  assign write_a_o         = out_res_q.wa;
  assign result_b_o        = out_res_q.rb;
  assign write_b_o         = out_res_q.wb;
  assign remainder_o       = out_res_q.rem;
  assign write_remainder_o = out_res_q.wr;
  assign cond_code_o       = out_cc_q;
  assign branch_taken_o    = out_res_q.br;
  assign halt_o            = out_res_q.halt;
  assign error_code_o      = out_res_q.err;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted while one is in execution");
  a_err_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o != vac_pkg::ERR_NONE)
      |-> !write_a_o && !write_b_o && !write_remainder_o)
    else $error("faulting item writes a register");
  a_swap_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_b_o |-> write_a_o)
    else $error("operand B written without operand A");
  a_cc_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cond_code_o != 2'd3))
    else $error("condition code holds an unused pattern");
`endif

endmodule
